### sv/swm_pkg.sv
// Shared types and constants for the stack with middle access.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_POP      = 2'd1,
    REQ_READ_MID = 2'd2,
    REQ_DEL_MID  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             shift_en;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic [IDX_W-1:0] rd_idx;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [6:0]               count;
  } res_t;

endpackage

### sv/swm_cell.sv
// One storage cell of the stack chain, holding a single entry.
`timescale 1ns / 1ps
module swm_cell (
  input  logic                              clk,
  input  logic [swm_pkg::IDX_W-1:0]         cell_idx,
  input  swm_pkg::cell_ctl_t                ctl,
  input  logic signed [swm_pkg::DATA_W-1:0] wr_data,
  input  logic signed [swm_pkg::DATA_W-1:0] upper_data,
  output logic signed [swm_pkg::DATA_W-1:0] data,
  output logic signed [swm_pkg::DATA_W-1:0] rd_data
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.wr_en && (cell_idx == ctl.wr_idx)) begin
      data_nxt = wr_data;
    end else if (ctl.shift_en && (cell_idx >= ctl.lo_idx) && (cell_idx < ctl.hi_idx)) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (cell_idx == ctl.rd_idx) ? data_r : '0;

endmodule

### sv/swm_skid.sv
// Two-entry result buffer that lets a request be taken while a result waits.
`timescale 1ns / 1ps
module swm_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  swm_pkg::res_t load_res,
  input  logic          out_stall,
  output logic          full,
  output logic          out_valid,
  output swm_pkg::res_t out_res
);
  import swm_pkg::*;

  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic fire;

  assign fire = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (fire) begin
      main_vld_nxt = 1'b0;
    end
    if (skid_vld_r && fire) begin
      main_nxt     = skid_r;
      main_vld_nxt = 1'b1;
      skid_vld_nxt = 1'b0;
    end
    if (load) begin
      if (!main_vld_r || fire) begin
        main_nxt     = load_res;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = load_res;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule

### sv/stack_with_middle_access_core.sv
// Top level of the bounded stack with read and delete of its middle entry.
`timescale 1ns / 1ps
// The stack holds up to DEPTH signed 32-bit words in a row of cells, one
// entry per cell, with the bottom of the stack in cell zero. Each request
// (push, pop, read middle, delete middle) yields exactly one result, held
// in the result buffer: a value, a status and the new entry count. The
// middle is the entry at index floor(count/2). A push writes the cell at
// the current count, and a middle delete has every cell from the middle up
// to the one below the top copy its upper neighbor in the same clock, so
// the chain sustains one request per cycle while the result buffer has
// room. It holds two results: after the result side stalls, one more
// request is taken and further ones are held off until a result transfer
// frees a slot. Cells above the count are never read and need no reset.
module stack_with_middle_access_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic signed [swm_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [swm_pkg::DATA_W-1:0] out_result_value,
  output logic [1:0]                        out_status,
  output logic [6:0]                        out_entry_count
);
  import swm_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             buf_full;
  req_t             req;
  cell_ctl_t        ctl;
  res_t             res;
  res_t             out_res;
  logic             empty;
  logic             full;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] mid_idx;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_rd   [DEPTH];
  logic signed [DATA_W-1:0] rd_value;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;
  assign req      = req_t'(in_req_type);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign count_m1 = count_r - CNT_W'(1);
  assign mid_idx  = IDX_W'(count_r >> 1);

  // Decode the request into cell control and the next count.
  always_comb begin
    ctl          = '0;
    ctl.wr_idx   = IDX_W'(count_r);
    ctl.lo_idx   = mid_idx;
    ctl.hi_idx   = IDX_W'(count_m1);
    ctl.rd_idx   = mid_idx;
    count_nxt    = count_r;
    if (accept) begin
      case (req)
        REQ_PUSH: begin
          if (!full) begin
            ctl.wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP: begin
          ctl.rd_idx = IDX_W'(count_m1);
          if (!empty) begin
            count_nxt = count_m1;
          end
        end
        REQ_READ_MID: begin
          ctl.rd_idx = mid_idx;
        end
        REQ_DEL_MID: begin
          if (!empty) begin
            ctl.shift_en = 1'b1;
            count_nxt    = count_m1;
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Only the addressed cell drives its value onto the read bus.
  always_comb begin
    rd_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_value = rd_value | cell_rd[k];
    end
  end

  // Assemble the result of the request being taken this cycle.
  always_comb begin
    res.value  = '0;
    res.status = ST_OK;
    res.count  = 7'(count_nxt);
    case (req)
      REQ_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end
      end
      REQ_POP, REQ_READ_MID, REQ_DEL_MID: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = rd_value;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[g + 1];
    end
    swm_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .wr_data    (in_push_value),
      .upper_data (upper),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  swm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_res  (res),
    .out_stall (out_stall),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_result_value = out_res.value;
  assign out_status       = out_res.status;
  assign out_entry_count  = out_res.count;

endmodule
